[hdl/l234hc_pkg.sv]
// Shared constants, result codes and the result record of the header classifier.
// Used by l234hc_parser and l2_l3_l4_header_classifier; depends on nothing.
`default_nettype none

package l234hc_pkg;

    // Frame length limit and the widths that follow from it
    localparam int MAX_FRAME_BYTES = 16384;
    localparam int IDX_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int OFF_W           = 14;
    // Header end can run one extension header (up to 2048 bytes) and a TCP header past the limit
    localparam int HEND_RAW_W      = $clog2(MAX_FRAME_BYTES + 2048 + 64 + 1);
    localparam int HEND_W          = (HEND_RAW_W > OFF_W) ? HEND_RAW_W : OFF_W + 1;
    localparam int CMP_W           = HEND_W + 1;

    localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

    // Verdict codes
    localparam logic [2:0] V_ACCEPT     = 3'd0;
    localparam logic [2:0] V_TRUNCATED  = 3'd1;
    localparam logic [2:0] V_NOT_IP     = 3'd2;
    localparam logic [2:0] V_BAD_NH     = 3'd3;
    localparam logic [2:0] V_WRONG_PORT = 3'd4;
    localparam logic [2:0] V_TOO_LONG   = 3'd5;

    // Transport kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_UDP  = 2'd1;
    localparam logic [1:0] KIND_TCP  = 2'd2;

    // Protocol numbers and EtherTypes
    localparam logic [7:0]  PROTO_HOPOPT  = 8'd0;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_ROUTING = 8'd43;
    localparam logic [7:0]  PROTO_FRAG    = 8'd44;
    localparam logic [7:0]  PROTO_AH      = 8'd51;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;

    localparam logic [15:0] PORT_RESET = 16'd53;

    localparam int RESULT_W = 3 + 2 + OFF_W;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [2:0]       verdict;
        logic [1:0]       kind;
        logic [OFF_W-1:0] offset;
    } result_t;

endpackage

`default_nettype wire

[hdl/l2_l3_l4_header_classifier.sv]
// Top level: stream ports, input stage, result register and the port register.
// Depends on l234hc_pkg and l234hc_parser.
// Throughput: one frame byte per cycle, with no gaps between frames, while the input stage does not stall.
// The final byte is held in the input register; when it moves on, the parser's verdict is loaded
//   into the result register, which drives m_tvalid.
// The input stage stalls only when a final byte meets a result still waiting on m_tready.
// Reset: asynchronous, clears the frame state and the stages; the port register resets to 53.
`default_nettype none

module l2_l3_l4_header_classifier
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // frame byte stream
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] frame_byte
    input  wire logic                             s_tlast,   // last_byte
    // verdict stream
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [l234hc_pkg::TDATA_W-1:0]   m_tdata,   // [2:0] verdict, [4:3] transport_kind,
                                                             // [18:5] payload_offset, rest zero
    // port register write
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [15:0]                      cfg_data   // wanted_source_port
);
    import l234hc_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    logic [15:0] port_reg;
    logic        advance;
    result_t     res;

    // Move the held byte on unless its result would land on a full output
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(TDATA_W - RESULT_W)'(0), out_res_reg.offset,
                        out_res_reg.kind, out_res_reg.verdict};

    l234hc_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (advance),
        .frame_byte  (in_byte_reg),
        .last_byte   (in_last_reg),
        .wanted_port (port_reg),
        .res         (res)
    );

    // Control: input stage, result stage and the port register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            port_reg      <= PORT_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
                port_reg <= cfg_data;
        end
    end

    // Payload: capture the byte and the finished verdict
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
            out_res_reg <= res;
    end

    // A result appears only after a final byte was processed
    a_res_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result raised without a final byte");

    // Only an accepted frame carries a payload offset
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.verdict != V_ACCEPT) |-> out_res_reg.offset == '0)
        else $error("payload offset set on a rejected frame");

    // Verdict codes stay within the defined set
    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_res_reg.verdict <= V_TOO_LONG)
        else $error("verdict code out of range");

endmodule

`default_nettype wire

[hdl/l234hc_parser.sv]
// Per-frame parse state and the one-byte step of the header walk.
// Depends on l234hc_pkg for widths, codes and result_t.
`default_nettype none

module l234hc_parser
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [7:0]          frame_byte,
    input  wire logic                last_byte,
    input  wire logic [15:0]         wanted_port,
    output l234hc_pkg::result_t      res
);
    import l234hc_pkg::*;

    // Parse phases
    localparam logic [3:0] PH_ETH      = 4'd0;
    localparam logic [3:0] PH_IP4      = 4'd1;
    localparam logic [3:0] PH_IP6      = 4'd2;
    localparam logic [3:0] PH_EXT_HEAD = 4'd3;
    localparam logic [3:0] PH_EXT_SKIP = 4'd4;
    localparam logic [3:0] PH_UDP      = 4'd5;
    localparam logic [3:0] PH_TCP_HEAD = 4'd6;
    localparam logic [3:0] PH_TCP_REST = 4'd7;
    localparam logic [3:0] PH_DONE     = 4'd8;

    logic [IDX_W-1:0]  idx_reg,   idx_next;
    logic [3:0]        phase_reg, phase_next;
    logic [HEND_W-1:0] hend_reg,  hend_next;
    logic [7:0]        proto_reg, proto_next;
    logic [15:0]       top_reg,   top_next;
    logic [2:0]        verd_reg,  verd_next;
    logic [1:0]        kind_reg,  kind_next;

    // One byte of the header walk
    always_comb
    begin
        logic [CMP_W-1:0] ic;
        logic [CMP_W-1:0] hc;
        logic             disp;
        logic             enter;
        logic             fin;
        logic [3:0]       nib;
        logic [11:0]      ext_len;
        logic [2:0]       v;

        idx_next   = idx_reg;
        phase_next = phase_reg;
        hend_next  = hend_reg;
        proto_next = proto_reg;
        top_next   = top_reg;
        verd_next  = verd_reg;
        kind_next  = kind_reg;
        disp       = 1'b0;
        enter      = 1'b0;
        fin        = 1'b0;
        nib        = 4'd0;
        ext_len    = 12'd0;
        ic         = CMP_W'(idx_reg);
        hc         = CMP_W'(hend_reg);
        v          = V_TRUNCATED;
        res        = '0;

        if (ic >= CMP_W'(MAX_FRAME_BYTES))
        begin
            verd_next  = V_TOO_LONG;
            phase_next = PH_DONE;
        end
        else
        begin
            idx_next = idx_reg + IDX_W'(1);
            case (phase_reg)
                PH_ETH:
                begin
                    if (ic == CMP_W'(12))
                        top_next = {frame_byte, 8'd0};
                    if (ic == CMP_W'(13))
                    begin
                        top_next = {top_reg[15:8], frame_byte};
                        if (top_next == ETYPE_IPV4)
                            phase_next = PH_IP4;
                        else if (top_next == ETYPE_IPV6)
                        begin
                            phase_next = PH_IP6;
                            hend_next  = HEND_W'(54);
                        end
                        else
                        begin
                            verd_next  = V_NOT_IP;
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_IP4:
                begin
                    nib = frame_byte[3:0];
                    if (ic == CMP_W'(14) && nib < 4'd5)
                    begin
                        verd_next  = V_BAD_NH;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (ic == CMP_W'(14))
                            hend_next = HEND_W'(14) + HEND_W'({nib, 2'b00});
                        if (ic == CMP_W'(23))
                            proto_next = frame_byte;
                        if (ic + CMP_W'(1) == CMP_W'(hend_next))
                        begin
                            if (proto_next == PROTO_TCP || proto_next == PROTO_UDP)
                                enter = 1'b1;
                            else
                            begin
                                verd_next  = V_BAD_NH;
                                phase_next = PH_DONE;
                            end
                        end
                    end
                end
                PH_IP6:
                begin
                    if (ic == CMP_W'(20))
                        proto_next = frame_byte;
                    disp = (ic + CMP_W'(1) == hc);
                end
                PH_EXT_HEAD:
                begin
                    if (ic == hc)
                        top_next = {8'd0, frame_byte};
                    else if (ic == hc + CMP_W'(1))
                    begin
                        if (proto_reg == PROTO_AH)
                            ext_len = {({2'b00, frame_byte} + 10'd2), 2'b00};
                        else
                            ext_len = {({1'b0, frame_byte} + 9'd1), 3'b000};
                        hend_next  = HEND_W'(hc + CMP_W'(ext_len));
                        proto_next = top_reg[7:0];
                        phase_next = PH_EXT_SKIP;
                    end
                end
                PH_EXT_SKIP:
                begin
                    disp = (ic + CMP_W'(1) == hc);
                end
                PH_UDP:
                begin
                    if (ic + CMP_W'(8) == hc)
                        top_next = {frame_byte, 8'd0};
                    if (ic + CMP_W'(7) == hc)
                        top_next = {top_reg[15:8], frame_byte};
                    fin = 1'b1;
                end
                PH_TCP_HEAD:
                begin
                    nib = frame_byte[7:4];
                    if (ic + CMP_W'(20) == hc)
                        top_next = {frame_byte, 8'd0};
                    if (ic + CMP_W'(19) == hc)
                        top_next = {top_reg[15:8], frame_byte};
                    if (ic + CMP_W'(8) == hc)
                    begin
                        if (nib < 4'd5)
                        begin
                            verd_next  = V_BAD_NH;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            hend_next  = hend_reg - HEND_W'(20) + HEND_W'({nib, 2'b00});
                            phase_next = PH_TCP_REST;
                        end
                    end
                end
                PH_TCP_REST:
                begin
                    fin = 1'b1;
                end
                default:
                begin
                end
            endcase

            // Choose the next header after IPv6 or an extension header
            if (disp)
            begin
                if (proto_next == PROTO_TCP || proto_next == PROTO_UDP)
                    enter = 1'b1;
                else if (proto_next == PROTO_HOPOPT || proto_next == PROTO_ROUTING ||
                         proto_next == PROTO_FRAG || proto_next == PROTO_AH)
                    phase_next = PH_EXT_HEAD;
                else
                begin
                    verd_next  = V_BAD_NH;
                    phase_next = PH_DONE;
                end
            end

            // Step into the transport header that starts at the current header end
            if (enter)
            begin
                if (proto_next == PROTO_UDP)
                begin
                    kind_next  = KIND_UDP;
                    hend_next  = hend_next + HEND_W'(8);
                    phase_next = PH_UDP;
                end
                else
                begin
                    kind_next  = KIND_TCP;
                    hend_next  = hend_next + HEND_W'(20);
                    phase_next = PH_TCP_HEAD;
                end
            end

            // Judge the source port on the last transport header byte
            if (fin && ic + CMP_W'(1) == hc)
            begin
                verd_next  = (top_next == wanted_port) ? V_ACCEPT : V_WRONG_PORT;
                phase_next = PH_DONE;
            end
        end

        // Build the verdict on the final byte and clear the frame state
        if (last_byte)
        begin
            v = (phase_next == PH_DONE) ? verd_next : V_TRUNCATED;
            res.verdict = v;
            res.kind    = kind_next;
            if (v == V_ACCEPT)
                res.offset = (hend_next > HEND_W'(OFF_MAX)) ? OFF_MAX : OFF_W'(hend_next);
            idx_next   = '0;
            phase_next = PH_ETH;
            hend_next  = HEND_W'(14);
            proto_next = 8'd0;
            top_next   = 16'd0;
            verd_next  = V_ACCEPT;
            kind_next  = KIND_NONE;
        end
    end

    // Advance the frame state on each byte taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            phase_reg <= PH_ETH;
            hend_reg  <= HEND_W'(14);
            proto_reg <= 8'd0;
            top_reg   <= 16'd0;
            verd_reg  <= V_ACCEPT;
            kind_reg  <= KIND_NONE;
        end
        else if (take)
        begin
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            hend_reg  <= hend_next;
            proto_reg <= proto_next;
            top_reg   <= top_next;
            verd_reg  <= verd_next;
            kind_reg  <= kind_next;
        end
    end

    // A settled frame stays settled until its final byte
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE && !(take && last_byte)) |=> phase_reg == PH_DONE)
        else $error("parse phase left done before the final byte");

    // The byte counter never runs past the frame limit
    a_idx_sat: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(idx_reg) <= CMP_W'(MAX_FRAME_BYTES))
        else $error("byte counter ran past the frame limit");

endmodule

`default_nettype wire
